// ===== hw/rtl/mavg_pkg.sv =====
// Shared constants, register codes and controller/datapath types for the moving average map.
package mavg_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int OUT_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int WINDOW_DEF = 10;
	localparam int DIV_CNT_W  = $clog2(OUT_W);

	localparam logic [SAMPLE_W-1:0] IN_LO_RST  = SAMPLE_W'(4054);
	localparam logic [SAMPLE_W-1:0] IN_HI_RST  = SAMPLE_W'(901);
	localparam logic [OUT_W-1:0]    OUT_LO_RST = OUT_W'(0);
	localparam logic [OUT_W-1:0]    OUT_HI_RST = OUT_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IN_LO  = 2'd0,
		CFG_IN_HI  = 2'd1,
		CFG_OUT_LO = 2'd2,
		CFG_OUT_HI = 2'd3
	} mavg_reg_t;

	typedef struct packed {
		logic load;
		logic update;
		logic prep;
		logic mult;
		logic div_step;
		logic emit;
	} mavg_cmd_t;

	typedef struct packed {
		logic clamp;
		logic out_free;
	} mavg_sts_t;

endpackage

// ===== hw/rtl/mavg_sample_if.sv =====
// Valid/ready channel that carries one converter sample per transaction.
interface mavg_sample_if
	import mavg_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/mavg_level_if.sv =====
// Valid/ready channel that carries one mapped level per transaction.
interface mavg_level_if
	import mavg_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] level;

	modport source (output valid, output level, input ready);
	modport sink   (input valid, input level, output ready);
endinterface

// ===== hw/rtl/mavg_ctrl.sv =====
// Controller state machine that sequences one sample through the datapath.
module mavg_ctrl
	import mavg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output mavg_cmd_t cmd,
	input  mavg_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.update   = (state_q == ST_UPD);
		cmd.prep     = (state_q == ST_PREP);
		cmd.mult     = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.emit     = (state_q == ST_OUT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= sts.clamp ? ST_OUT : ST_MUL;
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(OUT_W - 1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/mavg_datapath.sv =====
// Datapath: sample ring, running sum, clamp decision, multiplier, serial divider, output register.
module mavg_datapath
	import mavg_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mavg_cmd_t             cmd,
	output mavg_sts_t             sts,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic [OUT_W-1:0]      level,
	output logic                  level_valid,
	input  logic                  level_ready,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW + 1);
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int PROD_W = SUM_W + OUT_W;

	logic [SAMPLE_W-1:0] in_lo_q, in_hi_q;
	logic [OUT_W-1:0]    out_lo_q, out_hi_q;

	logic [SAMPLE_W-1:0] ring_mem [WINDOW];
	logic [WINDOW-1:0]   ring_vld_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] old_q;
	logic                old_vld_q;
	logic [SUM_W-1:0]    sum_q;

	logic                clamp_q;
	logic [OUT_W-1:0]    clamp_val_q;
	logic [SUM_W-1:0]    dist_q, den_q;
	logic                neg_q;
	logic [OUT_W-1:0]    dmag_q;
	logic [SUM_W-1:0]    rem_q;
	logic [OUT_W-1:0]    quo_q;

	logic [OUT_W-1:0]    level_q;
	logic                level_valid_q;

	logic [SUM_W-1:0]    lo_w, hi_w, old_w;
	logic                fwd, at_lo, at_hi, ge;
	logic [PROD_W-1:0]   prod;
	logic [SUM_W:0]      trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_lo_q  <= IN_LO_RST;
			in_hi_q  <= IN_HI_RST;
			out_lo_q <= OUT_LO_RST;
			out_hi_q <= OUT_HI_RST;
		end else if (cfg_we) begin
			unique case (mavg_reg_t'(cfg_idx))
				CFG_IN_LO:  in_lo_q  <= cfg_wdata[SAMPLE_W-1:0];
				CFG_IN_HI:  in_hi_q  <= cfg_wdata[SAMPLE_W-1:0];
				CFG_OUT_LO: out_lo_q <= cfg_wdata[OUT_W-1:0];
				CFG_OUT_HI: out_hi_q <= cfg_wdata[OUT_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) old_q <= ring_mem[slot_q];
		if (cmd.update) ring_mem[slot_q] <= sample_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			slot_q     <= '0;
			sum_q      <= '0;
			old_vld_q  <= 1'b0;
		end else begin
			if (cmd.load) old_vld_q <= ring_vld_q[slot_q];
			if (cmd.update) begin
				ring_vld_q[slot_q] <= 1'b1;
				sum_q              <= sum_q - old_w + SUM_W'(sample_q);
				slot_q             <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

	assign old_w = old_vld_q ? SUM_W'(old_q) : '0;

	always_ff @(posedge clk) begin
		if (cmd.load) sample_q <= sample;
	end

	assign lo_w = SUM_W'(in_lo_q) * SUM_W'(WINDOW);
	assign hi_w = SUM_W'(in_hi_q) * SUM_W'(WINDOW);
	assign fwd  = in_lo_q < in_hi_q;

	always_comb begin
		if (fwd) begin
			at_lo = sum_q <= lo_w;
			at_hi = sum_q >= hi_w;
		end else begin
			at_lo = sum_q >= lo_w;
			at_hi = sum_q <= hi_w;
		end
	end

	assign sts.clamp    = at_lo || at_hi;
	assign sts.out_free = !level_valid_q || level_ready;

	assign prod  = PROD_W'(dist_q) * PROD_W'(dmag_q);
	assign trial = {rem_q, quo_q[OUT_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			clamp_q     <= at_lo || at_hi;
			clamp_val_q <= at_lo ? out_lo_q : out_hi_q;
			dist_q      <= fwd ? sum_q - lo_w : lo_w - sum_q;
			den_q       <= fwd ? hi_w - lo_w : lo_w - hi_w;
			neg_q       <= out_hi_q < out_lo_q;
			dmag_q      <= (out_hi_q < out_lo_q) ? out_lo_q - out_hi_q : out_hi_q - out_lo_q;
		end
		if (cmd.mult) begin
			rem_q <= prod[PROD_W-1:OUT_W];
			quo_q <= prod[OUT_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? SUM_W'(trial - {1'b0, den_q}) : trial[SUM_W-1:0];
			quo_q <= {quo_q[OUT_W-2:0], ge};
		end
		if (cmd.emit) begin
			level_q <= clamp_q ? clamp_val_q : (neg_q ? out_lo_q - quo_q : out_lo_q + quo_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			level_valid_q <= 1'b1;
		end else if (level_ready) begin
			level_valid_q <= 1'b0;
		end
	end

	assign level       = level_q;
	assign level_valid = level_valid_q;

endmodule

// ===== hw/rtl/moving_average_calibrated_map.sv =====
// Top level of the moving average sensor map with clamped linear calibration.
//
//  channel    dir  width  transaction
//  sample_ch  in   12     one converter sample, valid & ready
//  level_ch   out  8      one mapped level per sample, valid & ready
//  cfg_*      in   12     register write when cfg_we is high, no read-back
//
// A sample runs through ring read, sum update, clamp check, multiply, 8 divider
// steps and output load when the mean falls between the calibration ends, and
// skips multiply and divider when it clamps. Reset clears the ring valid bits,
// the sum, the write slot and the output valid flag, and presets calibration.
// A full output register holds the controller in its last state until taken;
// a new sample is taken once that result is loaded.
module moving_average_calibrated_map
	import mavg_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mavg_sample_if.sink           sample_ch,
	mavg_level_if.source          level_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	mavg_cmd_t cmd;
	mavg_sts_t sts;

	mavg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (sample_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mavg_datapath #(
		.WINDOW (WINDOW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample      (sample_ch.sample),
		.level       (level_ch.level),
		.level_valid (level_ch.valid),
		.level_ready (level_ch.ready),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata)
	);

endmodule
